// ===== src/rie_pkg.sv =====
// Shared types, constants and helpers for the road impact event classifier.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package rie_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned MAG_W      = 16;
    localparam int unsigned SPEED_W    = 12;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned CAT_W      = 2;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_START_THRESHOLD   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_THRESHOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_GAP_MS    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX_EVENT_MS      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POTHOLE_THRESHOLD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SEVERE_THRESHOLD  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BUMPER_THRESHOLD  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DETECT_SPEED  = 3'd7;

    localparam logic [CAT_W-1:0] CAT_NORMAL  = 2'd0;
    localparam logic [CAT_W-1:0] CAT_BUMPER  = 2'd1;
    localparam logic [CAT_W-1:0] CAT_POTHOLE = 2'd2;

    localparam int unsigned DEF_POTHOLE_MIN_SPEED       = 100;
    localparam int unsigned DEF_BUMPER_MAX_SPEED        = 300;
    localparam int unsigned DEF_POTHOLE_MAX_DURATION_MS = 150;
    localparam int unsigned DEF_BUMPER_MIN_DURATION_MS  = 200;

    // Square steps of the magnitude sequencer: three products plus one drain step.
    localparam logic [CNT_W-1:0] SQ_LAST_STEP   = 4'd3;
    localparam logic [CNT_W-1:0] ROOT_FIRST_STEP = 4'd15;
    localparam logic [SUM_W-1:0] ROOT_FIRST_BIT = 32'h4000_0000;

    typedef enum logic [1:0] {
        MAG_IDLE,
        MAG_SQUARE,
        MAG_ROOT,
        MAG_HOLD
    } mag_state_t;

    typedef struct packed {
        logic [MAG_W-1:0]   start_threshold;
        logic [MAG_W-1:0]   release_threshold;
        logic [TIME_W-1:0]  release_gap_ms;
        logic [TIME_W-1:0]  max_event_ms;
        logic [MAG_W-1:0]   pothole_threshold;
        logic [MAG_W-1:0]   severe_threshold;
        logic [MAG_W-1:0]   bumper_threshold;
        logic [SPEED_W-1:0] min_detect_speed;
    } cfg_t;

    typedef struct packed {
        logic               detected;
        logic [CAT_W-1:0]   category;
        logic [MAG_W-1:0]   severity;
    } result_t;

    // Absolute value of a signed axis sample; the most negative code gives 32768.
    function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] r;
        r = v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/rie_if.sv =====
// Word channels of the classifier: sample channel and result channel.
// Depends on rie_pkg for field widths.
`default_nettype none

interface rie_sample_if;
    logic                              valid;
    logic                              ready;
    logic signed [rie_pkg::AXIS_W-1:0] accel_x;
    logic signed [rie_pkg::AXIS_W-1:0] accel_y;
    logic signed [rie_pkg::AXIS_W-1:0] accel_z;
    logic [rie_pkg::SPEED_W-1:0]       vehicle_speed;
    logic [rie_pkg::TIME_W-1:0]        time_ms;

    modport source (output valid, accel_x, accel_y, accel_z, vehicle_speed, time_ms,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, vehicle_speed, time_ms,
                  output ready);
endinterface

interface rie_result_if;
    logic                        valid;
    logic                        ready;
    logic                        detected;
    logic [rie_pkg::CAT_W-1:0]   category;
    logic [rie_pkg::MAG_W-1:0]   severity;

    modport source (output valid, detected, category, severity, input ready);
    modport sink (input valid, detected, category, severity, output ready);
endinterface

`default_nettype wire

// ===== src/rie_cfg.sv =====
// APB-style configuration register file of the classifier.
// Depends on rie_pkg for the register map and the configuration struct.
`default_nettype none

module rie_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rie_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rie_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rie_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output rie_pkg::cfg_t                         cfg
);

    rie_pkg::cfg_t                  cfg_reg;
    logic [rie_pkg::REG_IDX_W-1:0]  idx;
    logic                           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[rie_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                rie_pkg::REG_START_THRESHOLD:
                    cfg_reg.start_threshold <= pwdata[rie_pkg::MAG_W-1:0];
                rie_pkg::REG_RELEASE_THRESHOLD:
                    cfg_reg.release_threshold <= pwdata[rie_pkg::MAG_W-1:0];
                rie_pkg::REG_RELEASE_GAP_MS:
                    cfg_reg.release_gap_ms <= pwdata[rie_pkg::TIME_W-1:0];
                rie_pkg::REG_MAX_EVENT_MS:
                    cfg_reg.max_event_ms <= pwdata[rie_pkg::TIME_W-1:0];
                rie_pkg::REG_POTHOLE_THRESHOLD:
                    cfg_reg.pothole_threshold <= pwdata[rie_pkg::MAG_W-1:0];
                rie_pkg::REG_SEVERE_THRESHOLD:
                    cfg_reg.severe_threshold <= pwdata[rie_pkg::MAG_W-1:0];
                rie_pkg::REG_BUMPER_THRESHOLD:
                    cfg_reg.bumper_threshold <= pwdata[rie_pkg::MAG_W-1:0];
                rie_pkg::REG_MIN_DETECT_SPEED:
                    cfg_reg.min_detect_speed <= pwdata[rie_pkg::SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rie_pkg::REG_START_THRESHOLD:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.start_threshold);
            rie_pkg::REG_RELEASE_THRESHOLD:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.release_threshold);
            rie_pkg::REG_RELEASE_GAP_MS:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.release_gap_ms);
            rie_pkg::REG_MAX_EVENT_MS:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.max_event_ms);
            rie_pkg::REG_POTHOLE_THRESHOLD:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.pothole_threshold);
            rie_pkg::REG_SEVERE_THRESHOLD:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.severe_threshold);
            rie_pkg::REG_BUMPER_THRESHOLD:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.bumper_threshold);
            rie_pkg::REG_MIN_DETECT_SPEED:
                prdata = rie_pkg::APB_DATA_W'(cfg_reg.min_detect_speed);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/rie_mag.sv =====
// Iterative magnitude unit: one multiplier squares the axes in turn, then one
// add-and-compare unit extracts the integer square root a bit per cycle.
// Depends on rie_pkg.
`default_nettype none

module rie_mag (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rie_pkg::AXIS_W-1:0]    accel_x,
    input  wire logic [rie_pkg::AXIS_W-1:0]    accel_y,
    input  wire logic [rie_pkg::AXIS_W-1:0]    accel_z,
    input  wire logic                          take,
    output logic                               in_ready,
    output logic                               mag_valid,
    output logic      [rie_pkg::MAG_W-1:0]     mag
);

    rie_pkg::mag_state_t            state_reg, state_next;
    logic [rie_pkg::CNT_W-1:0]      cnt_reg;
    logic [rie_pkg::AXIS_W-1:0]     axis_reg [3];
    logic [rie_pkg::SUM_W-1:0]      prod_reg;
    logic [rie_pkg::SUM_W-1:0]      sum_reg;
    logic [rie_pkg::SUM_W-1:0]      root_reg;
    logic [rie_pkg::SUM_W-1:0]      bit_reg;
    logic [rie_pkg::AXIS_W-1:0]     axis_sel;
    logic [rie_pkg::AXIS_W-1:0]     axis_abs;
    logic [rie_pkg::SUM_W-1:0]      trial;
    logic                           fits;
    logic                           sq_phase;
    logic                           root_phase;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rie_pkg::MAG_IDLE:
                if (start)
                    state_next = rie_pkg::MAG_SQUARE;
            rie_pkg::MAG_SQUARE:
                if (cnt_reg == rie_pkg::SQ_LAST_STEP)
                    state_next = rie_pkg::MAG_ROOT;
            rie_pkg::MAG_ROOT:
                if (cnt_reg == '0)
                    state_next = rie_pkg::MAG_HOLD;
            rie_pkg::MAG_HOLD:
                if (take)
                    state_next = rie_pkg::MAG_IDLE;
            default:
                state_next = rie_pkg::MAG_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        mag_valid  = 1'b0;
        sq_phase   = 1'b0;
        root_phase = 1'b0;
        case (state_reg)
            rie_pkg::MAG_IDLE:   in_ready   = 1'b1;
            rie_pkg::MAG_SQUARE: sq_phase   = 1'b1;
            rie_pkg::MAG_ROOT:   root_phase = 1'b1;
            rie_pkg::MAG_HOLD:   mag_valid  = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rie_pkg::MAG_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start && in_ready)
                cnt_reg <= '0;
            else if (sq_phase && cnt_reg == rie_pkg::SQ_LAST_STEP)
                cnt_reg <= rie_pkg::ROOT_FIRST_STEP;
            else if (sq_phase)
                cnt_reg <= cnt_reg + rie_pkg::CNT_W'(1);
            else if (root_phase && cnt_reg != '0)
                cnt_reg <= cnt_reg - rie_pkg::CNT_W'(1);
        end
    end

    // Axis selected for the multiplier in the current square step.
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    axis_sel = axis_reg[0];
            2'd1:    axis_sel = axis_reg[1];
            2'd2:    axis_sel = axis_reg[2];
            default: axis_sel = '0;
        endcase
    end

    assign axis_abs = rie_pkg::abs_axis(axis_sel);
    assign trial    = root_reg + bit_reg;
    assign fits     = sum_reg >= trial;
    assign mag      = root_reg[rie_pkg::MAG_W-1:0];

    // The product is registered and added in the next step, so the last square
    // step only drains the pipeline. In the root phase sum_reg is the remainder.
    always_ff @(posedge clk)
    begin
        if (start && in_ready)
        begin
            axis_reg[0] <= accel_x;
            axis_reg[1] <= accel_y;
            axis_reg[2] <= accel_z;
        end
        if (sq_phase)
        begin
            prod_reg <= axis_abs * axis_abs;
            if (cnt_reg == rie_pkg::CNT_W'(1))
                sum_reg <= prod_reg;
            else if (cnt_reg != '0)
                sum_reg <= sum_reg + prod_reg;
            root_reg <= '0;
            bit_reg  <= rie_pkg::ROOT_FIRST_BIT;
        end
        else if (root_phase)
        begin
            if (fits)
            begin
                sum_reg  <= sum_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

`default_nettype wire

// ===== src/rie_evt.sv =====
// Event tracker and classifier: holds the open event and forms one result word
// for each finished magnitude. Depends on rie_pkg.
`default_nettype none

module rie_evt #(
    parameter int unsigned POTHOLE_MIN_SPEED       = rie_pkg::DEF_POTHOLE_MIN_SPEED,
    parameter int unsigned BUMPER_MAX_SPEED        = rie_pkg::DEF_BUMPER_MAX_SPEED,
    parameter int unsigned POTHOLE_MAX_DURATION_MS = rie_pkg::DEF_POTHOLE_MAX_DURATION_MS,
    parameter int unsigned BUMPER_MIN_DURATION_MS  = rie_pkg::DEF_BUMPER_MIN_DURATION_MS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire logic [rie_pkg::MAG_W-1:0]     mag,
    input  wire logic [rie_pkg::SPEED_W-1:0]   speed,
    input  wire logic [rie_pkg::TIME_W-1:0]    now,
    input  wire rie_pkg::cfg_t                 cfg,
    output rie_pkg::result_t                   res
);

    localparam logic [rie_pkg::SPEED_W-1:0] PMIN_SPEED =
        rie_pkg::SPEED_W'(POTHOLE_MIN_SPEED);
    localparam logic [rie_pkg::SPEED_W-1:0] BMAX_SPEED =
        rie_pkg::SPEED_W'(BUMPER_MAX_SPEED);
    localparam logic [rie_pkg::TIME_W-1:0]  PMAX_DUR =
        rie_pkg::TIME_W'(POTHOLE_MAX_DURATION_MS);
    localparam logic [rie_pkg::TIME_W-1:0]  BMIN_DUR =
        rie_pkg::TIME_W'(BUMPER_MIN_DURATION_MS);

    logic                           active_reg, active_next;
    logic [rie_pkg::MAG_W-1:0]      peak_reg, peak_next;
    logic [rie_pkg::SPEED_W-1:0]    speed_reg, speed_next;
    logic [rie_pkg::TIME_W-1:0]     start_reg, start_next;
    logic [rie_pkg::TIME_W-1:0]     last_reg, last_next;

    logic [rie_pkg::MAG_W-1:0]      peak_upd;
    logic [rie_pkg::TIME_W-1:0]     last_upd;
    logic [rie_pkg::TIME_W-1:0]     duration;
    logic [rie_pkg::TIME_W-1:0]     quiet;
    logic                           closing;
    logic                           is_pothole;
    logic                           is_bumper;

    always_comb
    begin
        peak_upd   = (mag > peak_reg) ? mag : peak_reg;
        last_upd   = (mag >= cfg.release_threshold) ? now : last_reg;
        duration   = now - start_reg;
        quiet      = now - last_upd;
        closing    = (quiet >= cfg.release_gap_ms) || (duration >= cfg.max_event_ms);
        is_pothole = (speed_reg >= PMIN_SPEED) &&
                     (((duration <= PMAX_DUR) && (peak_upd >= cfg.pothole_threshold)) ||
                      (peak_upd >= cfg.severe_threshold));
        is_bumper  = (speed_reg <= BMAX_SPEED) && (duration >= BMIN_DUR) &&
                     (peak_upd >= cfg.bumper_threshold);

        active_next = active_reg;
        peak_next   = peak_reg;
        speed_next  = speed_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        res.detected = 1'b0;
        res.category = rie_pkg::CAT_NORMAL;

        if (!active_reg)
        begin
            res.severity = mag;
            if ((speed >= cfg.min_detect_speed) && (mag >= cfg.start_threshold))
            begin
                active_next = 1'b1;
                peak_next   = mag;
                speed_next  = speed;
                start_next  = now;
                last_next   = now;
            end
        end
        else
        begin
            res.severity = peak_upd;
            peak_next    = peak_upd;
            last_next    = last_upd;
            if (closing)
            begin
                active_next = 1'b0;
                peak_next   = '0;
                speed_next  = '0;
                start_next  = '0;
                last_next   = '0;
                if (is_pothole)
                begin
                    res.detected = 1'b1;
                    res.category = rie_pkg::CAT_POTHOLE;
                end
                else if (is_bumper)
                begin
                    res.detected = 1'b1;
                    res.category = rie_pkg::CAT_BUMPER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            peak_reg   <= '0;
            speed_reg  <= '0;
            start_reg  <= '0;
            last_reg   <= '0;
        end
        else if (take)
        begin
            active_reg <= active_next;
            peak_reg   <= peak_next;
            speed_reg  <= speed_next;
            start_reg  <= start_next;
            last_reg   <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/road_impact_event_classifier.sv =====
// Road impact event classifier, top level. A sample word accepted by the idle
// sequencer goes through 4 square steps on the shared 16x16 multiplier, then
// 16 root steps on the shared add-and-compare unit, and is then handed over to
// the event tracker and the output register. A new sample word is taken only
// once the sequencer is idle again; a stalled result port holds it back.
// rst_n clears the configuration registers, event and control state asynchronously.
`default_nettype none

module road_impact_event_classifier #(
    parameter int unsigned POTHOLE_MIN_SPEED       = rie_pkg::DEF_POTHOLE_MIN_SPEED,
    parameter int unsigned BUMPER_MAX_SPEED        = rie_pkg::DEF_BUMPER_MAX_SPEED,
    parameter int unsigned POTHOLE_MAX_DURATION_MS = rie_pkg::DEF_POTHOLE_MAX_DURATION_MS,
    parameter int unsigned BUMPER_MIN_DURATION_MS  = rie_pkg::DEF_BUMPER_MIN_DURATION_MS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rie_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [rie_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rie_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    rie_sample_if.sink                            sample,
    rie_result_if.source                          result
);

    rie_pkg::cfg_t                   cfg;
    rie_pkg::result_t                res;
    logic                            accept;
    logic                            mag_valid;
    logic                            take;
    logic [rie_pkg::MAG_W-1:0]       mag;
    logic [rie_pkg::SPEED_W-1:0]     speed_reg;
    logic [rie_pkg::TIME_W-1:0]      time_reg;
    logic                            out_valid_reg;
    rie_pkg::result_t                out_reg;

    // APB regs: the user writes them only while no word is in flight; not enforced.
    rie_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The magnitude unit is ready only when idle; the sample's speed and time
    // are held here while it works.
    assign accept = sample.valid && sample.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speed_reg <= sample.vehicle_speed;
            time_reg  <= sample.time_ms;
        end
    end

    rie_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sample.valid),
        .accel_x   (sample.accel_x),
        .accel_y   (sample.accel_y),
        .accel_z   (sample.accel_z),
        .take      (take),
        .in_ready  (sample.ready),
        .mag_valid (mag_valid),
        .mag       (mag)
    );

    // A finished magnitude is handed to the event tracker only when the output
    // register is free or being emptied in the same cycle, so the event state
    // advances exactly once per result word.
    assign take = mag_valid && (!out_valid_reg || result.ready);

    rie_evt #(
        .POTHOLE_MIN_SPEED       (POTHOLE_MIN_SPEED),
        .BUMPER_MAX_SPEED        (BUMPER_MAX_SPEED),
        .POTHOLE_MAX_DURATION_MS (POTHOLE_MAX_DURATION_MS),
        .BUMPER_MIN_DURATION_MS  (BUMPER_MIN_DURATION_MS)
    ) u_evt (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .mag   (mag),
        .speed (speed_reg),
        .now   (time_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Output register: holds the result word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= res;
    end

    assign result.valid    = out_valid_reg;
    assign result.detected = out_reg.detected;
    assign result.category = out_reg.category;
    assign result.severity = out_reg.severity;

endmodule

`default_nettype wire
